// File: hw/rtl/brf_pkg.sv
// Shared types and constants for the byte ring FIFO with block transfers.
// No dependencies; every other file imports this package.
package brf_pkg;

  localparam int BUFFER_BYTES_DEF = 64;
  localparam int BYTE_W = 8;
  localparam int LEN_W = 6;
  localparam int FUNC_W = 3;
  localparam int CNT_MAX = 63;

  localparam logic [FUNC_W-1:0] FUNC_ENQ = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_DEQ = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_PEEK = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_SKIP = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_CLR = 3'd4;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [BYTE_W-1:0] data_byte;
    logic [LEN_W-1:0]  request_len;
    logic              block_end;
  } brf_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              run_end;
    logic [LEN_W-1:0]  accepted_len;
    logic              status;
    logic [LEN_W-1:0]  used_bytes;
    logic [LEN_W-1:0]  free_bytes;
  } brf_out_t;

  // port enables from the sequencer to the byte store
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } brf_mem_ctl_t;

endpackage

// File: hw/rtl/brf_store.sv
// Byte store of the ring FIFO: one write port, one read port, registered read data.
// Depends on brf_pkg.
module brf_store import brf_pkg::*; #(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
  localparam int PW = $clog2(BUFFER_BYTES)
) (
  input  logic              clk,
  input  brf_mem_ctl_t      mem_ctl,
  input  logic [PW-1:0]     waddr,
  input  logic [BYTE_W-1:0] wdata,
  input  logic [PW-1:0]     raddr,
  output logic [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0] mem_r [BUFFER_BYTES];
  logic [BYTE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (mem_ctl.wr_en) begin
      mem_r[waddr] <= wdata;
    end
    if (mem_ctl.rd_en) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/brf_ctrl.sv
// Sequencer of the ring FIFO: pointers, fill count, block admission, read runs
// and the output register. Depends on brf_pkg; drives the ports of brf_store.
module brf_ctrl import brf_pkg::*; #(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
  localparam int PW = $clog2(BUFFER_BYTES)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  brf_in_t           in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output brf_out_t          out_data,
  output brf_mem_ctl_t      mem_ctl,
  output logic [PW-1:0]     waddr,
  output logic [BYTE_W-1:0] wdata,
  output logic [PW-1:0]     raddr,
  input  logic [BYTE_W-1:0] rdata
);

  localparam int CW = (PW > LEN_W) ? PW : LEN_W;
  localparam int SW = CW + 1;
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic             state_r, state_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    used_r, used_nxt;
  logic             in_block_r, in_block_nxt;
  logic             admitted_r, admitted_nxt;
  logic [LEN_W-1:0] blk_left_r, blk_left_nxt;
  logic [LEN_W-1:0] blk_len_r, blk_len_nxt;
  logic [LEN_W-1:0] run_left_r, run_left_nxt;
  logic [LEN_W-1:0] run_acc_r, run_acc_nxt;
  logic [PW-1:0]    rd_addr_r, rd_addr_nxt;
  logic             out_valid_r, out_valid_nxt;
  brf_out_t         out_r, out_nxt;

  logic             in_fire, slot_free, load_out;
  logic [PW-1:0]    free_cnt, free_nxt;
  logic [CW-1:0]    len_ext;
  logic             len_zero, data_short;
  logic             enq_admit, enq_store;
  logic [LEN_W-1:0] enq_len, enq_left;
  logic [LEN_W-1:0] res_acc;
  logic [BYTE_W-1:0] res_byte;
  logic             res_end, res_refused;

  // ring pointer plus a short step, wrapping at the buffer size
  function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] ptr,
                                             input logic [LEN_W-1:0] inc);
    logic [SW-1:0] sum;
    sum = SW'(ptr) + SW'(inc);
    if (sum >= SW'(BUFFER_BYTES)) begin
      sum = sum - SW'(BUFFER_BYTES);
    end
    return sum[PW-1:0];
  endfunction

  function automatic logic [LEN_W-1:0] sat_cnt(input logic [PW-1:0] v);
    logic [CW-1:0] ve;
    ve = CW'(v);
    return (ve > CW'(CNT_MAX)) ? LEN_W'(CNT_MAX) : ve[LEN_W-1:0];
  endfunction

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) && slot_free;
  assign in_fire = in_valid && in_ready;

  assign free_cnt = PW'(BUFFER_BYTES - 1) - used_r;
  assign len_ext = CW'(in_data.request_len);
  assign len_zero = (in_data.request_len == '0);
  assign data_short = CW'(used_r) < len_ext;

  // the first byte of a block decides admission; later bytes use latched values
  assign enq_admit = in_block_r ? admitted_r : (CW'(free_cnt) >= len_ext);
  assign enq_len = in_block_r ? blk_len_r : in_data.request_len;
  assign enq_left = in_block_r ? blk_left_r
                  : ((CW'(free_cnt) >= len_ext) ? in_data.request_len : '0);
  assign enq_store = enq_admit && (enq_left != '0);

  always_comb begin
    state_nxt = state_r;
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    used_nxt = used_r;
    in_block_nxt = in_block_r;
    admitted_nxt = admitted_r;
    blk_left_nxt = blk_left_r;
    blk_len_nxt = blk_len_r;
    run_left_nxt = run_left_r;
    run_acc_nxt = run_acc_r;
    rd_addr_nxt = rd_addr_r;
    mem_ctl = '0;
    raddr = rd_ptr_r;
    load_out = 1'b0;
    res_byte = '0;
    res_end = 1'b1;
    res_acc = '0;
    res_refused = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_data.func)
            FUNC_ENQ: begin
              load_out = 1'b1;
              res_acc = enq_admit ? enq_len : '0;
              res_refused = !enq_admit;
              admitted_nxt = enq_admit;
              blk_len_nxt = enq_len;
              if (enq_store) begin
                mem_ctl.wr_en = 1'b1;
                wr_ptr_nxt = wrap_add(wr_ptr_r, LEN_W'(1));
                used_nxt = used_r + PW'(1);
              end
              if (in_data.block_end) begin
                in_block_nxt = 1'b0;
                blk_left_nxt = '0;
              end else begin
                in_block_nxt = 1'b1;
                blk_left_nxt = enq_left - LEN_W'(enq_store);
              end
            end
            FUNC_DEQ, FUNC_PEEK: begin
              if (len_zero || data_short) begin
                load_out = 1'b1;
                res_refused = !len_zero;
              end else begin
                if (in_data.func == FUNC_DEQ) begin
                  rd_ptr_nxt = wrap_add(rd_ptr_r, in_data.request_len);
                  used_nxt = used_r - PW'(in_data.request_len);
                end
                mem_ctl.rd_en = 1'b1;
                raddr = rd_ptr_r;
                rd_addr_nxt = wrap_add(rd_ptr_r, LEN_W'(1));
                run_left_nxt = in_data.request_len;
                run_acc_nxt = in_data.request_len;
                state_nxt = ST_READ;
              end
            end
            FUNC_SKIP: begin
              load_out = 1'b1;
              if (len_zero) begin
                res_refused = 1'b0;
              end else if (data_short) begin
                res_refused = 1'b1;
              end else begin
                rd_ptr_nxt = wrap_add(rd_ptr_r, in_data.request_len);
                used_nxt = used_r - PW'(in_data.request_len);
                res_acc = in_data.request_len;
              end
            end
            FUNC_CLR: begin
              load_out = 1'b1;
              rd_ptr_nxt = '0;
              wr_ptr_nxt = '0;
              used_nxt = '0;
              in_block_nxt = 1'b0;
              admitted_nxt = 1'b0;
              blk_left_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        // rdata holds the byte fetched in the previous issue cycle
        if (slot_free) begin
          load_out = 1'b1;
          res_byte = rdata;
          res_acc = run_acc_r;
          res_end = (run_left_r == LEN_W'(1));
          run_left_nxt = run_left_r - LEN_W'(1);
          if (run_left_r == LEN_W'(1)) begin
            state_nxt = ST_IDLE;
          end else begin
            mem_ctl.rd_en = 1'b1;
            raddr = rd_addr_r;
            rd_addr_nxt = wrap_add(rd_addr_r, LEN_W'(1));
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign free_nxt = PW'(BUFFER_BYTES - 1) - used_nxt;

  always_comb begin
    out_nxt = out_r;
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_nxt.out_byte = res_byte;
      out_nxt.run_end = res_end;
      out_nxt.accepted_len = res_acc;
      out_nxt.status = res_refused;
      out_nxt.used_bytes = sat_cnt(used_nxt);
      out_nxt.free_bytes = sat_cnt(free_nxt);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign waddr = wr_ptr_r;
  assign wdata = in_data.data_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      used_r <= '0;
      in_block_r <= 1'b0;
      admitted_r <= 1'b0;
      blk_left_r <= '0;
      run_left_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      used_r <= used_nxt;
      in_block_r <= in_block_nxt;
      admitted_r <= admitted_nxt;
      blk_left_r <= blk_left_nxt;
      run_left_r <= run_left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_len_r <= blk_len_nxt;
    run_acc_r <= run_acc_nxt;
    rd_addr_r <= rd_addr_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

endmodule

// File: hw/rtl/byte_ring_fifo_block_transfer.sv
// Top level of the byte ring FIFO with all-or-nothing block transfers.
// Depends on brf_pkg, brf_ctrl and brf_store.
//
//  channel | ports                         | moves
//  --------+-------------------------------+-------------------------------------
//  in      | in_valid, in_ready, in_data   | one request (enqueue byte or command)
//  out     | out_valid, out_ready, out_data| one result (byte, counts, status)
//
// Enqueue, skip, clear and refused or zero-length reads each give one result.
// A granted dequeue or peek of N bytes first fetches the first byte from the store's
// registered read port, then returns one byte per cycle while out_ready does not stall.
// The store reads at most once per cycle; no new request is taken during a read run.
// Reset (rst_n low, synchronous) empties the FIFO and closes any open block.
// A stalled out_ready holds the result register and blocks further requests.
module byte_ring_fifo_block_transfer import brf_pkg::*; #(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  brf_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output brf_out_t out_data
);

  localparam int PW = $clog2(BUFFER_BYTES);

  brf_mem_ctl_t      mem_ctl;
  logic [PW-1:0]     waddr;
  logic [PW-1:0]     raddr;
  logic [BYTE_W-1:0] wdata;
  logic [BYTE_W-1:0] rdata;

  brf_ctrl #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .mem_ctl  (mem_ctl),
    .waddr    (waddr),
    .wdata    (wdata),
    .raddr    (raddr),
    .rdata    (rdata)
  );

  brf_store #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_store (
    .clk    (clk),
    .mem_ctl(mem_ctl),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr  (raddr),
    .rdata  (rdata)
  );

endmodule

// File: hw/rtl/brf_checker.sv
// Port-level checks for the byte ring FIFO, bound to the top level.
// Depends on brf_pkg and byte_ring_fifo_block_transfer.
module brf_checker import brf_pkg::*; #(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input brf_in_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input brf_out_t out_data
);

  // no result survives reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // a refusal is a single result with nothing accepted
  a_refusal_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status |-> out_data.run_end && out_data.accepted_len == '0)
    else $error("refusal result malformed");

  // used and free always add up to capacity while both fit unsaturated
  a_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (BUFFER_BYTES <= CNT_MAX + 1) |->
      (7'(out_data.used_bytes) + 7'(out_data.free_bytes) == 7'(BUFFER_BYTES - 1)))
    else $error("used plus free differs from capacity");

  // a read run streams without gaps and keeps its length and counts
  a_run_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.run_end |=>
      out_valid && out_data.accepted_len == $past(out_data.accepted_len) &&
      out_data.used_bytes == $past(out_data.used_bytes))
    else $error("read run broken");

  // an unused function code produces no result
  a_unused_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.func > FUNC_CLR) && !out_valid |=> !out_valid)
    else $error("result produced for unused code");

endmodule

bind byte_ring_fifo_block_transfer brf_checker #(
  .BUFFER_BYTES(BUFFER_BYTES)
) u_brf_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

// File: sim/tb_byte_ring_fifo_block_transfer.sv
// Self-checking testbench for byte_ring_fifo_block_transfer: queued requests in,
// results checked field by field against an in-bench ring FIFO predictor.
// Depends on brf_pkg and the byte_ring_fifo_block_transfer RTL.
module tb_byte_ring_fifo_block_transfer;
  import brf_pkg::*;

  localparam int DEPTH = BUFFER_BYTES_DEF;
  localparam int RAND_ITEMS = 195;
  localparam int CYCLE_LIMIT = 5000000;
  localparam int TAIL_CYCLES = DEPTH + 16;
  localparam int HOLD_CYCLES = 200;
  localparam int MAX_PRINTS = 60;

  logic     clk;
  logic     rst_n;
  logic     in_valid = 1'b0;
  logic     in_ready;
  brf_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  brf_out_t out_data;

  byte_ring_fifo_block_transfer dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  // request stream and expected results
  brf_in_t  pend_q[$];
  brf_out_t want_q[$];
  brf_out_t want_res;

  // predictor state
  logic [BYTE_W-1:0] ring [DEPTH];
  int rd_ptr = 0;
  int wr_ptr = 0;
  bit blk_open = 1'b0;
  bit blk_ok = 1'b0;
  int blk_len = 0;
  int blk_owed = 0;

  logic [FUNC_W-1:0] read_ops [3] = '{FUNC_DEQ, FUNC_PEEK, FUNC_SKIP};

  int cyc = 0;
  int errors = 0;
  int n_req = 0;
  int n_res = 0;
  int n_refused = 0;
  int n_blocks = 0;
  int n_holds = 0;
  int hold_cnt = 0;
  int in_gap = 0;
  int out_gap = 0;
  bit in_calm = 1'b0;
  bit out_calm = 1'b0;
  bit nxt_valid;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic flag(input string what);
    errors++;
    if (errors <= MAX_PRINTS) $display("ERROR cycle %0d: %s", cyc, what);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) flag($sformatf("result %0d %s got %0d want %0d", n_res, name, got, want));
  endtask

  function automatic int fill_used();
    return (wr_ptr + DEPTH - rd_ptr) % DEPTH;
  endfunction

  function automatic int sat_cnt(input int v);
    return (v > CNT_MAX) ? CNT_MAX : v;
  endfunction

  task automatic push_result(input logic [BYTE_W-1:0] b, input logic last, input int acc,
                             input logic refused);
    brf_out_t r;
    r.out_byte = b;
    r.run_end = last;
    r.accepted_len = acc[LEN_W-1:0];
    r.status = refused;
    r.used_bytes = LEN_W'(sat_cnt(fill_used()));
    r.free_bytes = LEN_W'(sat_cnt(DEPTH - 1 - fill_used()));
    want_q.push_back(r);
  endtask

  task automatic apply_request(input brf_in_t rq);
    int start;
    int len;
    int k;
    start = rd_ptr;
    len = rq.request_len;
    case (rq.func)
      FUNC_ENQ: begin
        // first byte of a block decides admission for the whole block
        if (!blk_open) begin
          blk_open = 1'b1;
          blk_len = len;
          blk_ok = (DEPTH - 1 - fill_used()) >= len;
          blk_owed = blk_ok ? len : 0;
        end
        if (blk_ok && blk_owed > 0) begin
          ring[wr_ptr] = rq.data_byte;
          wr_ptr = (wr_ptr + 1) % DEPTH;
          blk_owed--;
        end
        push_result('0, 1'b1, blk_ok ? blk_len : 0, !blk_ok);
        if (rq.block_end) begin
          blk_open = 1'b0;
          blk_owed = 0;
        end
      end
      FUNC_DEQ, FUNC_PEEK: begin
        if (len == 0) push_result('0, 1'b1, 0, 1'b0);
        else if (fill_used() < len) push_result('0, 1'b1, 0, 1'b1);
        else begin
          if (rq.func == FUNC_DEQ) rd_ptr = (rd_ptr + len) % DEPTH;
          for (k = 0; k < len; k++)
            push_result(ring[(start + k) % DEPTH], k + 1 == len, len, 1'b0);
        end
      end
      FUNC_SKIP: begin
        if (len == 0) push_result('0, 1'b1, 0, 1'b0);
        else if (fill_used() < len) push_result('0, 1'b1, 0, 1'b1);
        else begin
          rd_ptr = (rd_ptr + len) % DEPTH;
          push_result('0, 1'b1, len, 1'b0);
        end
      end
      FUNC_CLR: begin
        rd_ptr = 0;
        wr_ptr = 0;
        blk_open = 1'b0;
        blk_ok = 1'b0;
        blk_owed = 0;
        push_result('0, 1'b1, 0, 1'b0);
      end
      default: ;  // unused codes are dropped silently
    endcase
  endtask

  function automatic int draw_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int draw_len(input int big_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 0;
    if (r < 100 - big_pct) return $urandom_range(1, 10);
    return $urandom_range(11, 63);
  endfunction

  task automatic add_req(input logic [FUNC_W-1:0] f, input int d, input int l, input logic e);
    brf_in_t r;
    r.func = f;
    r.data_byte = d[BYTE_W-1:0];
    r.request_len = l[LEN_W-1:0];
    r.block_end = e;
    pend_q.push_back(r);
  endtask

  // one enqueue block, mostly well formed; some short, some long, some with
  // reads slipped in while the block is open
  task automatic add_block(output int cnt);
    int len;
    int nb;
    int shape;
    int k;
    len = draw_len(6);
    shape = $urandom_range(0, 9);
    nb = (len == 0) ? 1 : len;
    if (shape == 0) nb = $urandom_range(1, nb);
    else if (shape == 1) nb = nb + $urandom_range(1, 4);
    cnt = 0;
    n_blocks++;
    for (k = 0; k < nb; k++) begin
      if (k > 0 && $urandom_range(0, 19) == 0) begin
        add_req(read_ops[$urandom_range(0, 2)], $urandom_range(0, 255), $urandom_range(0, 6),
                1'($urandom_range(0, 1)));
        cnt++;
      end
      add_req(FUNC_ENQ, $urandom_range(0, 255), (k == 0) ? len : $urandom_range(0, 63),
              k == nb - 1);
      cnt++;
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      nxt_valid = in_valid;
      if (in_valid && in_ready) begin
        apply_request(in_data);
        n_req++;
        if (n_req % 40 == 0) in_calm = ($urandom_range(0, 3) == 0);
        nxt_valid = 1'b0;
        in_gap = draw_gap(in_calm);
      end
      if (!nxt_valid) begin
        if (in_gap > 0) in_gap--;
        else if (pend_q.size() != 0) begin
          in_data <= pend_q.pop_front();
          nxt_valid = 1'b1;
        end
      end
      in_valid <= nxt_valid;
    end
  end

  // result side back-pressure, with two long hold-offs that stall the result channel
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else if ((n_req >= 60 && n_holds == 0) || (n_req >= 170 && n_holds == 1)) begin
      hold_cnt = HOLD_CYCLES;
      n_holds++;
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) out_gap = draw_gap(out_calm);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      n_res++;
      if (n_res % 40 == 0) out_calm = ($urandom_range(0, 3) == 0);
      if (out_data.status) n_refused++;
      if (want_q.size() == 0) begin
        flag($sformatf("result %0d arrived with nothing expected", n_res));
      end else begin
        want_res = want_q.pop_front();
        check_field("out_byte", out_data.out_byte, want_res.out_byte);
        check_field("run_end", out_data.run_end, want_res.run_end);
        check_field("accepted_len", out_data.accepted_len, want_res.accepted_len);
        check_field("status", out_data.status, want_res.status);
        check_field("used_bytes", out_data.used_bytes, want_res.used_bytes);
        check_field("free_bytes", out_data.free_bytes, want_res.free_bytes);
      end
    end
  end

  always @(posedge clk) begin
    cyc++;
    if (cyc > CYCLE_LIMIT) begin
      $display("timeout: %0d requests pending, %0d results outstanding",
               pend_q.size(), want_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int n_rand;
    int pick;
    int cnt;
    rst_n = 1'b0;

    // directed: empty reads, zero lengths, short/long/refused blocks, clear
    // inside an open block, unused codes
    add_req(FUNC_DEQ, 0, 0, 1'b0);
    add_req(FUNC_DEQ, 0, 1, 1'b0);
    add_req(FUNC_PEEK, 0, 1, 1'b0);
    add_req(FUNC_SKIP, 0, 1, 1'b0);
    add_req(FUNC_SKIP, 0, 0, 1'b0);
    add_req(FUNC_ENQ, 8'h77, 0, 1'b1);
    add_req(FUNC_ENQ, 8'h00, 3, 1'b0);
    add_req(FUNC_ENQ, 8'hff, 3, 1'b0);
    add_req(FUNC_ENQ, 8'ha5, 3, 1'b1);
    add_req(FUNC_PEEK, 0, 3, 1'b1);
    add_req(FUNC_PEEK, 0, 0, 1'b0);
    add_req(FUNC_DEQ, 0, 2, 1'b0);
    add_req(FUNC_SKIP, 0, 1, 1'b0);
    add_req(FUNC_ENQ, 8'h5a, 63, 1'b0);
    add_req(FUNC_ENQ, 8'hc3, 63, 1'b1);
    add_req(FUNC_DEQ, 0, 63, 1'b0);
    add_req(FUNC_ENQ, 8'h99, 62, 1'b1);
    add_req(FUNC_ENQ, 8'h11, 2, 1'b0);
    add_req(FUNC_ENQ, 8'h22, 40, 1'b0);
    add_req(FUNC_ENQ, 8'h33, 2, 1'b0);
    add_req(FUNC_ENQ, 8'h44, 2, 1'b1);
    add_req(FUNC_DEQ, 0, 4, 1'b0);
    add_req(FUNC_ENQ, 8'h81, 5, 1'b0);
    add_req(FUNC_CLR, 8'hff, 63, 1'b1);
    add_req(3'd5, 8'hff, 63, 1'b1);
    add_req(3'd6, 0, 1, 1'b0);
    add_req(3'd7, 0, 0, 1'b0);
    add_req(FUNC_ENQ, 8'h3c, 1, 1'b1);
    add_req(FUNC_DEQ, 0, 1, 1'b0);

    n_rand = 0;
    while (n_rand < RAND_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        add_block(cnt);
        n_rand += cnt;
      end else if (pick < 58) begin
        add_req(FUNC_DEQ, $urandom_range(0, 255), draw_len(8), 1'($urandom_range(0, 1)));
        n_rand++;
      end else if (pick < 70) begin
        add_req(FUNC_PEEK, $urandom_range(0, 255), draw_len(8), 1'($urandom_range(0, 1)));
        n_rand++;
      end else if (pick < 80) begin
        add_req(FUNC_SKIP, $urandom_range(0, 255), draw_len(8), 1'($urandom_range(0, 1)));
        n_rand++;
      end else if (pick < 84) begin
        add_req(FUNC_CLR, $urandom_range(0, 255), $urandom_range(0, 63),
                1'($urandom_range(0, 1)));
        n_rand++;
      end else if (pick < 87) begin
        add_req(FUNC_W'($urandom_range(5, 7)), $urandom_range(0, 255), $urandom_range(0, 63),
                1'($urandom_range(0, 1)));
      end else begin
        // unstructured request, may break an open block
        add_req(FUNC_W'($urandom_range(0, 4)), $urandom_range(0, 255), $urandom_range(0, 63),
                1'($urandom_range(0, 1)));
        n_rand++;
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (pend_q.size() != 0 || in_valid || want_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (want_q.size() != 0) flag($sformatf("%0d expected results never arrived", want_q.size()));

    $display("ran %0d requests (%0d enqueue blocks) and checked %0d results, %0d refused",
             n_req, n_blocks, n_res, n_refused);
    $display("output held off %0d times for %0d cycles; %0d mismatches",
             n_holds, HOLD_CYCLES, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
